FILE: hdl/memory_limited_admission_scheduler_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the memory-limited admission scheduler
// Implication checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MEMORY_LIMITED_ADMISSION_SCHEDULER_MACROS_SVH
`define MEMORY_LIMITED_ADMISSION_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

`define MLAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MLAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MLAS_ASSERT_NOW(label, ante, cons, msg)

`define MLAS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hdl/mlas_pkg.sv
// ---------------------------------------------------------------------------
// mlas_pkg
// Word types, event codes and register indexes of the admission scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlas_pkg;

  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_KILL   = 1'b1;

  localparam logic [2:0] EV_TOO_LARGE  = 3'd0;
  localparam logic [2:0] EV_QUEUED     = 3'd1;
  localparam logic [2:0] EV_QUEUE_FULL = 3'd2;
  localparam logic [2:0] EV_KILLED     = 3'd3;
  localparam logic [2:0] EV_NOT_FOUND  = 3'd4;
  localparam logic [2:0] EV_ADMITTED   = 3'd5;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CAP   = 1'd1;

  localparam logic [3:0]  MAX_SLOTS_RST = 4'd8;
  localparam logic [15:0] MEM_CAP_RST   = 16'hFFFF;

  typedef struct packed {
    logic        action;
    logic [15:0] job_id;
    logic [15:0] mem_need;
  } mlas_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] event_id;
    logic [2:0]  slot;
    logic [3:0]  running_jobs;
    logic [15:0] memory_used;
    logic        last;
  } mlas_out_t;

  typedef struct packed {
    logic push;
    logic fin;
  } mlas_evctl_t;

endpackage

FILE: hdl/mlas_ram.sv
// ---------------------------------------------------------------------------
// mlas_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hdl/mlas_out_stage.sv
// ---------------------------------------------------------------------------
// mlas_out_stage
// Hold the newest event until the next one or the end of the request shows
// whether it is the final word, then pass it to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlas_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  mlas_pkg::mlas_evctl_t ev_ctl,
  input  mlas_pkg::mlas_out_t ev_data,
  output logic                ev_ok,
  output logic                hold_busy,
  output logic                out_valid,
  input  logic                out_ready,
  output mlas_pkg::mlas_out_t out_data
);
  import mlas_pkg::*;

  logic      hold_v_r, hold_v_nxt;
  mlas_out_t hold_r, hold_nxt;
  logic      out_v_r, out_v_nxt;
  mlas_out_t out_r, out_nxt;
  logic      ofree;

  assign ofree     = !out_v_r || out_ready;
  assign ev_ok     = !hold_v_r || ofree;
  assign hold_busy = hold_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r && !out_ready;
    out_nxt    = out_r;
    if (ev_ctl.push && ev_ok) begin
      if (hold_v_r) begin
        out_nxt      = hold_r;
        out_nxt.last = 1'b0;
        out_v_nxt    = 1'b1;
      end
      hold_nxt   = ev_data;
      hold_v_nxt = 1'b1;
    end else if (ev_ctl.fin && ev_ok && hold_v_r) begin
      out_nxt      = hold_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: hdl/memory_limited_admission_scheduler.sv
// A create is decoded in S_DEC and rejected (too large, queue full) or queued; a queued one then drains the queue.
// A kill scans the slots (S_KSCAN, S_KCMP); if found it frees the slot and drains the pending queue.
// One request at a time; a request ends before the next is taken.
// The length of a request is set by the slot scan (S_KSCAN for every slot, S_KCMP also for a busy
// slot) and the pending-queue read (S_DRD, S_DCHK) per admission; output stalls add to it.
// Reset: synchronous, active low; busy bits and counters clear at once, no clearing pass.
// ---------------------------------------------------------------------------
// memory_limited_admission_scheduler
// FIFO admission control with a slot and memory limit, state held in RAMs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "memory_limited_admission_scheduler_macros.svh"

module memory_limited_admission_scheduler #(
  parameter int SLOTS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mlas_pkg::mlas_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mlas_pkg::mlas_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mlas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlas_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mlas_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_KSCAN, S_KCMP, S_DRD, S_DCHK, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  mlas_in_t         item_r, item_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0] run_cnt_r, run_cnt_nxt;
  logic [15:0]      mem_used_r, mem_used_nxt;
  logic [QW-1:0]    head_r, head_nxt;
  logic [QW-1:0]    tail_r, tail_nxt;
  logic [QCW-1:0]   pcnt_r, pcnt_nxt;
  logic [3:0]       max_slots_r;
  logic [15:0]      mem_cap_r;

  logic             slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  logic [31:0]      slot_wdata, slot_rdata;
  logic             pend_we;
  logic [31:0]      pend_wdata, pend_rdata;

  logic [SLOT_W-1:0] free_idx;
  logic             free_found;
  logic [SLOT_W-1:0] scan_idx;
  logic             run_ok;
  logic             fits;
  logic [16:0]      mem_sum;

  mlas_evctl_t      ev_ctl;
  mlas_out_t        ev_data;
  logic             ev_ok;
  logic             hold_busy;

  assign in_ready = (state_r == S_IDLE);
  assign scan_idx = scan_r[SLOT_W-1:0];

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_idx   = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign run_ok  = (8'(run_cnt_r) < 8'(max_slots_r)) && (8'(run_cnt_r) < 8'(SLOTS));
  assign mem_sum = {1'b0, mem_used_r} + {1'b0, pend_rdata[15:0]};
  assign fits    = mem_sum <= {1'b0, mem_cap_r};

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    scan_nxt     = scan_r;
    busy_nxt     = busy_r;
    run_cnt_nxt  = run_cnt_r;
    mem_used_nxt = mem_used_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    pcnt_nxt     = pcnt_r;
    slot_we      = 1'b0;
    slot_waddr   = free_idx;
    slot_wdata   = pend_rdata;
    pend_we      = 1'b0;
    pend_wdata   = {item_r.job_id, item_r.mem_need};
    ev_ctl       = '0;
    ev_data      = '0;
    ev_data.event_id = item_r.job_id;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (item_r.action == ACT_KILL) begin
          scan_nxt  = '0;
          state_nxt = S_KSCAN;
        end else if (ev_ok) begin
          ev_ctl.push = 1'b1;
          if (item_r.mem_need > mem_cap_r) begin
            ev_data.event_res = EV_TOO_LARGE;
            state_nxt         = S_FIN;
          end else if (pcnt_r == QCW'(QUEUE_DEPTH)) begin
            ev_data.event_res = EV_QUEUE_FULL;
            state_nxt         = S_FIN;
          end else begin
            pend_we  = 1'b1;
            tail_nxt = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            pcnt_nxt = pcnt_r + 1'b1;
            ev_data.event_res = EV_QUEUED;
            state_nxt         = S_DRD;
          end
        end
      end
      S_KSCAN: begin
        if (scan_r == CNT_W'(SLOTS)) begin
          if (ev_ok) begin
            ev_ctl.push       = 1'b1;
            ev_data.event_res = EV_NOT_FOUND;
            state_nxt         = S_FIN;
          end
        end else if (busy_r[scan_idx]) begin
          state_nxt = S_KCMP;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_KCMP: begin
        if (slot_rdata[31:16] == item_r.job_id) begin
          if (ev_ok) begin
            busy_nxt[scan_idx] = 1'b0;
            run_cnt_nxt  = run_cnt_r - 1'b1;
            mem_used_nxt = mem_used_r - slot_rdata[15:0];
            ev_ctl.push       = 1'b1;
            ev_data.event_res = EV_KILLED;
            ev_data.slot      = 3'(scan_r);
            state_nxt         = S_DRD;
          end
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_KSCAN;
        end
      end
      S_DRD: begin
        state_nxt = (pcnt_r == '0) ? S_FIN : S_DCHK;
      end
      S_DCHK: begin
        if (fits && run_ok && free_found) begin
          if (ev_ok) begin
            slot_we            = 1'b1;
            busy_nxt[free_idx] = 1'b1;
            run_cnt_nxt  = run_cnt_r + 1'b1;
            mem_used_nxt = mem_sum[15:0];
            head_nxt = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            pcnt_nxt = pcnt_r - 1'b1;
            ev_ctl.push       = 1'b1;
            ev_data.event_res = EV_ADMITTED;
            ev_data.event_id  = pend_rdata[31:16];
            ev_data.slot      = 3'(free_idx);
            state_nxt         = S_DRD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ev_ctl.fin = 1'b1;
        if (ev_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ev_data.running_jobs = 4'(run_cnt_nxt);
    ev_data.memory_used  = mem_used_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      run_cnt_r   <= '0;
      mem_used_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      pcnt_r      <= '0;
      max_slots_r <= MAX_SLOTS_RST;
      mem_cap_r   <= MEM_CAP_RST;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= busy_nxt;
      run_cnt_r  <= run_cnt_nxt;
      mem_used_r <= mem_used_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      pcnt_r     <= pcnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_SLOTS: max_slots_r <= cfg_wdata[3:0];
          CFG_MEM_CAP:   mem_cap_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    item_r <= item_nxt;
    scan_r <= scan_nxt;
  end

  mlas_ram #(
    .WIDTH(32),
    .DEPTH(SLOTS),
    .AW(SLOT_W)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .raddr(scan_idx),
    .rdata(slot_rdata)
  );

  mlas_ram #(
    .WIDTH(32),
    .DEPTH(QUEUE_DEPTH),
    .AW(QW)
  ) u_pend_ram (
    .clk  (clk),
    .we   (pend_we),
    .waddr(tail_r),
    .wdata(pend_wdata),
    .raddr(head_r),
    .rdata(pend_rdata)
  );

  mlas_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_ctl   (ev_ctl),
    .ev_data  (ev_data),
    .ev_ok    (ev_ok),
    .hold_busy(hold_busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `MLAS_ASSERT_NOW(a_run_matches_busy, 1'b1, run_cnt_r == $countones(busy_r), "run count differs from busy slots")
  `MLAS_ASSERT_NOW(a_queue_bound, 1'b1, pcnt_r <= QCW'(QUEUE_DEPTH), "pending count above queue depth")
  `MLAS_ASSERT_NOW(a_idle_flushed, state_r == S_IDLE, !hold_busy && (!out_valid || out_data.last), "idle with an unfinished result word")
  `MLAS_ASSERT_NEXT(a_accept_no_hold, in_valid && in_ready, !hold_busy, "held event at request start")

endmodule
